// ----- design/assert_macros.svh -----
// assertion macros shared by the list core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/olis_pkg.sv -----
// types, codes and sizes of the ordered list core
package olis_pkg;

  localparam int DEPTH  = 1024;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 11;
  localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
  localparam int LEAVES = 1 << IDX_W;
  localparam int NODES  = 2 * LEAVES - 1;
  localparam int WAIT_W = $clog2(IDX_W + 2);

  typedef logic [31:0] word_t;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_LOCATE = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef struct packed {
    req_t               req_type;
    logic [POS_W-1:0]   position;
    logic signed [31:0] value;
  } req_beat_t;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] found_position;
    logic [POS_W-1:0] count;
  } rsp_beat_t;

  typedef struct packed {
    logic             ins_en;
    logic             del_en;
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] count;
    word_t            data;
    word_t            key;
  } cell_ctl_t;

endpackage

// ----- design/olis_cell.sv -----
// one list cell: holds an entry, shifts with its neighbours, compares against the key
module olis_cell import olis_pkg::*; (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [IDX_W-1:0] cell_idx,
  input  word_t            prev_val,
  input  word_t            next_val,
  output word_t            val,
  output logic             hit
);

  always_ff @(posedge clk) begin
    if (ctl.ins_en && (cell_idx == ctl.slot)) begin
      val <= ctl.data;
    end else if (ctl.ins_en && (cell_idx > ctl.slot)) begin
      val <= prev_val;
    end else if (ctl.del_en && (cell_idx >= ctl.slot)) begin
      val <= next_val;
    end
    hit <= (val == ctl.key) && (CNT_W'(cell_idx) < ctl.count);
  end

endmodule

// ----- design/olis_find.sv -----
// registered first-match tree over the cell hit flags
module olis_find import olis_pkg::*; (
  input  logic             clk,
  input  logic [DEPTH-1:0] hits,
  output logic             found,
  output logic [IDX_W-1:0] found_idx
);

  logic             leaf_hit [LEAVES];
  logic [IDX_W-1:0] leaf_idx [LEAVES];
  logic             node_hit [NODES - LEAVES];
  logic [IDX_W-1:0] node_idx [NODES - LEAVES];

  for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
    if (j < DEPTH) begin : g_used
      assign leaf_hit[j] = hits[j];
    end else begin : g_pad
      assign leaf_hit[j] = 1'b0;
    end
    assign leaf_idx[j] = IDX_W'(j);
  end

  for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
    logic             left_hit;
    logic             right_hit;
    logic [IDX_W-1:0] left_idx;
    logic [IDX_W-1:0] right_idx;
    if (2*n + 1 >= LEAVES - 1) begin : g_from_leaf
      assign left_hit  = leaf_hit[2*n + 2 - LEAVES];
      assign right_hit = leaf_hit[2*n + 3 - LEAVES];
      assign left_idx  = leaf_idx[2*n + 2 - LEAVES];
      assign right_idx = leaf_idx[2*n + 3 - LEAVES];
    end else begin : g_from_node
      assign left_hit  = node_hit[2*n + 1];
      assign right_hit = node_hit[2*n + 2];
      assign left_idx  = node_idx[2*n + 1];
      assign right_idx = node_idx[2*n + 2];
    end
    always_ff @(posedge clk) begin
      node_hit[n] <= left_hit | right_hit;
      node_idx[n] <= left_hit ? left_idx : right_idx;
    end
  end

  assign found     = node_hit[0];
  assign found_idx = node_idx[0];

endmodule

// ----- design/ordered_list_insert_delete_search_core.sv -----
// Ordered list of DEPTH signed 32-bit entries kept in a row of shifting cells,
// with clear, insert, delete and locate requests and one response beat per request.
// Clear, insert and delete are applied in the cycle the request beat is taken.
// Locate compares every cell at once and then resolves the first match through
// a registered binary tree of log2(DEPTH) levels.
// A finished response waits in the output register until it is taken; no new
// request is taken until the previous response has moved into that register.
module ordered_list_insert_delete_search_core import olis_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_beat_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_beat_t rsp
);

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_FIND = 3'b010,
    S_PUSH = 3'b100
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic [WAIT_W-1:0] wait_cnt;
  word_t             key;
  rsp_beat_t         res;
  status_t           st;
  logic              ins_en;
  logic              del_en;
  logic              accept;
  logic              out_free;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  cell_ctl_t         ctl;
  word_t             vals [DEPTH];
  logic [DEPTH-1:0]  hits;
  logic              found;
  logic [IDX_W-1:0]  found_idx;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign pos_ext   = CMP_W'(req.position);
  assign cnt_ext   = CMP_W'(cnt);

  always_comb begin
    st       = ST_OK;
    ins_en   = 1'b0;
    del_en   = 1'b0;
    cnt_next = cnt;
    unique case (req.req_type)
      REQ_CLEAR: begin
        cnt_next = '0;
      end
      REQ_INSERT: begin
        if (cnt == CNT_W'(DEPTH)) begin
          st = ST_FULL;
        end else if ((pos_ext == '0) || (pos_ext > cnt_ext + CMP_W'(1))) begin
          st = ST_BADPOS;
        end else begin
          ins_en   = accept;
          cnt_next = cnt + CNT_W'(1);
        end
      end
      REQ_DELETE: begin
        if (cnt == '0) begin
          st = ST_EMPTY;
        end else if ((pos_ext == '0) || (pos_ext > cnt_ext)) begin
          st = ST_BADPOS;
        end else begin
          del_en   = accept;
          cnt_next = cnt - CNT_W'(1);
        end
      end
      REQ_LOCATE: begin
        st = ST_NOTFOUND;
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  assign ctl.ins_en = ins_en;
  assign ctl.del_en = del_en;
  assign ctl.slot   = IDX_W'(pos_ext - CMP_W'(1));
  assign ctl.count  = cnt;
  assign ctl.data   = word_t'(req.value);
  assign ctl.key    = key;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t prev_v;
    word_t next_v;
    if (i == 0) begin : g_first
      assign prev_v = '0;
    end else begin : g_prev
      assign prev_v = vals[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_v = '0;
    end else begin : g_next
      assign next_v = vals[i+1];
    end
    olis_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .cell_idx (IDX_W'(i)),
      .prev_val (prev_v),
      .next_val (next_v),
      .val      (vals[i]),
      .hit      (hits[i])
    );
  end

  olis_find u_find (
    .clk       (clk),
    .hits      (hits),
    .found     (found),
    .found_idx (found_idx)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      wait_cnt  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && (state != S_PUSH)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.req_type == REQ_LOCATE) begin
              wait_cnt <= WAIT_W'(IDX_W + 1);
              state    <= S_FIND;
            end else begin
              cnt   <= cnt_next;
              state <= S_PUSH;
            end
          end
        end
        S_FIND: begin
          if (wait_cnt == '0) begin
            state <= S_PUSH;
          end else begin
            wait_cnt <= wait_cnt - WAIT_W'(1);
          end
        end
        S_PUSH: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      key                <= word_t'(req.value);
      res.status         <= st;
      res.found_position <= '0;
      res.count          <= POS_W'(cnt_next);
    end else if ((state == S_FIND) && (wait_cnt == '0)) begin
      res.status         <= found ? ST_OK : ST_NOTFOUND;
      res.found_position <= found ? POS_W'(CNT_W'(found_idx) + CNT_W'(1)) : '0;
      res.count          <= POS_W'(cnt);
    end
    if ((state == S_PUSH) && out_free) begin
      rsp <= res;
    end
  end

  `ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1, cnt <= CNT_W'(DEPTH))
  `ASSERT_IMPLIES(a_found_only_ok, clk, rst, rsp_valid && (rsp.status != ST_OK), rsp.found_position == '0)
  `ASSERT_NEXT(a_locate_search, clk, rst, accept && (req.req_type == REQ_LOCATE), state == S_FIND)
  `ASSERT_NEXT(a_count_held, clk, rst, !accept, $stable(cnt))

endmodule

// ----- tb/ordered_list_insert_delete_search_core_test.sv -----
// self-checking testbench for the ordered list core: directed and random request beats checked against a list model
module ordered_list_insert_delete_search_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import olis_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    req_beat_t beat;
    bit        drain;
  } pending_item_t;

  logic      clk;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_beat_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_beat_t rsp;

  pending_item_t pending[$];
  word_t         plan_list[$];
  rsp_beat_t     expected_rsp[int];

  word_t list_cells[DEPTH];
  int    list_len = 0;

  int n_total = 0;
  int n_sent = 0;
  int n_got = 0;
  int n_errors = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 0;
  bit stall_rnd = 0;
  int stall_run = 0;
  int cycles = 0;

  ordered_list_insert_delete_search_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic word_t pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return word_t'($urandom_range(0, 7) - 4);
    if (r < 45) return 32'h8000_0000;
    if (r < 50) return 32'h7fff_ffff;
    return $urandom;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    n_errors++;
  endtask

  task automatic predict_list_op(input req_beat_t b, output rsp_beat_t r);
    int p;
    int k;
    int found;
    p = int'(b.position);
    found = 0;
    r.status = ST_OK;
    case (b.req_type)
      REQ_CLEAR: list_len = 0;
      REQ_INSERT: begin
        if (list_len >= DEPTH) r.status = ST_FULL;
        else if (p < 1 || p > list_len + 1) r.status = ST_BADPOS;
        else begin
          for (k = list_len; k >= p; k--) list_cells[k] = list_cells[k-1];
          list_cells[p-1] = word_t'(b.value);
          list_len++;
        end
      end
      REQ_DELETE: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else if (p < 1 || p > list_len) r.status = ST_BADPOS;
        else begin
          for (k = p - 1; k < list_len - 1; k++) list_cells[k] = list_cells[k+1];
          list_len--;
        end
      end
      default: begin
        for (k = 0; k < list_len && found == 0; k++)
          if (list_cells[k] == word_t'(b.value)) found = k + 1;
        r.status = (found != 0) ? ST_OK : ST_NOTFOUND;
      end
    endcase
    r.found_position = found[POS_W-1:0];
    r.count = list_len[POS_W-1:0];
  endtask

  task automatic add_item(input req_t op, input int unsigned pos, input word_t val,
                          input bit drain);
    pending_item_t it;
    int p;
    p = int'(pos[POS_W-1:0]);
    it.beat.req_type = op;
    it.beat.position = p[POS_W-1:0];
    it.beat.value = val;
    it.drain = drain;
    pending.push_back(it);
    n_total++;
    case (op)
      REQ_CLEAR: plan_list.delete();
      REQ_INSERT:
        if (plan_list.size() < DEPTH && p >= 1 && p <= plan_list.size() + 1)
          plan_list.insert(p - 1, val);
      REQ_DELETE:
        if (plan_list.size() != 0 && p >= 1 && p <= plan_list.size())
          plan_list.delete(p - 1);
      default: ;
    endcase
  endtask

  // request driver
  always @(posedge clk) begin
    rsp_beat_t pred;
    bit took;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      took = req_valid && !req_stall;
      if (took) begin
        predict_list_op(req, pred);
        expected_rsp[n_sent] = pred;
        n_sent <= n_sent + 1;
      end
      if (took || !req_valid) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          req_valid <= 1'b0;
        end else if (pending.size() != 0 &&
                     !(pending[0].drain && (took || n_got != n_sent))) begin
          req <= pending[0].beat;
          req_valid <= 1'b1;
          pending.pop_front();
          gap_left <= pick_gap();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the core backs up its request side
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 0;
    end else if (!hold_done && n_sent == 40) begin
      hold_left <= 400;
      hold_done <= 1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stall_rnd <= 0;
      stall_run <= 0;
      rsp_stall <= 1'b0;
    end else begin
      if (stall_run != 0) begin
        stall_run <= stall_run - 1;
      end else if ($urandom_range(0, 2) == 0) begin
        stall_rnd <= 1;
        stall_run <= pick_gap();
      end else begin
        stall_rnd <= 0;
        stall_run <= $urandom_range(1, 40);
      end
      rsp_stall <= (hold_left != 0) || stall_rnd;
    end
  end

  // response monitor
  always @(posedge clk) begin
    rsp_beat_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (n_got >= n_sent) begin
        report_mismatch($sformatf("beat %0d arrived with nothing outstanding", n_got));
      end else begin
        want = expected_rsp[n_got];
        if (rsp.status !== want.status)
          report_mismatch($sformatf("beat %0d status got %0d want %0d",
                                    n_got, rsp.status, want.status));
        if (rsp.found_position !== want.found_position)
          report_mismatch($sformatf("beat %0d found_position got %0d want %0d",
                                    n_got, rsp.found_position, want.found_position));
        if (rsp.count !== want.count)
          report_mismatch($sformatf("beat %0d count got %0d want %0d",
                                    n_got, rsp.count, want.count));
        expected_rsp.delete(n_got);
        n_got <= n_got + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int n;
    int r;
    int unsigned p;
    word_t v;

    // directed: empty list, extremes, first match, bad positions, clear
    add_item(REQ_LOCATE, 0, 32'h0, 0);
    add_item(REQ_DELETE, 1, 32'h0, 0);
    add_item(REQ_INSERT, 0, 32'h1, 0);
    add_item(REQ_INSERT, 2, 32'h1, 0);
    add_item(REQ_INSERT, 1, 32'h8000_0000, 0);
    add_item(REQ_INSERT, 2, 32'h7fff_ffff, 0);
    add_item(REQ_INSERT, 1, 32'h0, 0);
    add_item(REQ_INSERT, 4, 32'hffff_ffff, 0);
    add_item(REQ_INSERT, 2, 32'h7fff_ffff, 0);
    add_item(REQ_LOCATE, 0, 32'h7fff_ffff, 0);
    add_item(REQ_LOCATE, 2047, 32'hffff_ffff, 0);
    add_item(REQ_LOCATE, 0, 32'h0, 0);
    add_item(REQ_LOCATE, 0, 32'd12345, 0);
    add_item(REQ_INSERT, 7, 32'h5, 0);
    add_item(REQ_INSERT, 2047, 32'h5, 0);
    add_item(REQ_DELETE, 0, 32'h0, 0);
    add_item(REQ_DELETE, 6, 32'h0, 0);
    add_item(REQ_DELETE, 2047, 32'h0, 0);
    add_item(REQ_DELETE, 5, 32'h0, 0);
    add_item(REQ_DELETE, 1, 32'h0, 0);
    add_item(REQ_LOCATE, 0, 32'h0, 0);
    add_item(REQ_CLEAR, 2047, 32'hffff_ffff, 0);
    add_item(REQ_LOCATE, 0, 32'h7fff_ffff, 0);
    add_item(REQ_INSERT, 1, 32'h5, 0);
    add_item(REQ_CLEAR, 0, $urandom, 1);

    while (n_total < 400) begin
      r = $urandom_range(0, 9);
      if (r < 2) begin
        n = $urandom_range(1, 6);
        repeat (n)
          add_item(req_t'($urandom_range(0, 3)), $urandom_range(0, 2047), $urandom, 0);
      end else begin
        if ($urandom_range(0, 3) == 0)
          add_item(REQ_CLEAR, $urandom_range(0, 2047), $urandom, $urandom_range(0, 4) == 0);
        n = $urandom_range(1, 12);
        repeat (n) add_item(REQ_INSERT, $urandom_range(1, plan_list.size() + 1),
                            pick_value(), 0);
        n = $urandom_range(1, 6);
        repeat (n) begin
          if (plan_list.size() != 0 && $urandom_range(0, 3) != 0)
            v = plan_list[$urandom_range(0, plan_list.size() - 1)];
          else
            v = pick_value();
          add_item(REQ_LOCATE, $urandom_range(0, 2047), v, 0);
        end
        n = $urandom_range(0, 8);
        repeat (n) begin
          if ($urandom_range(0, 7) == 0) p = plan_list.size() + 1;
          else if (plan_list.size() == 0) p = 1;
          else p = $urandom_range(1, plan_list.size());
          add_item(REQ_DELETE, p, $urandom, 0);
        end
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (n_got != n_total) @(posedge clk);
    repeat (40) @(posedge clk);
    if (n_sent != n_got)
      report_mismatch($sformatf("%0d responses never arrived", n_sent - n_got));
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
